[hdl/bb3_pkg.sv]
// Shared types, constants and codes for the 3x3 border-aware box blur.
package bb3_pkg;

    // Geometry limits
    localparam int MAX_WIDTH  = 256;
    localparam int HEIGHT_CAP = 256;
    localparam int DIM_MIN    = 3;

    // Field and counter widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int W_W       = $clog2(MAX_WIDTH + 1);
    localparam int H_W       = $clog2(HEIGHT_CAP + 1);
    localparam int ROW_W     = $clog2(HEIGHT_CAP + 2);
    localparam int SUM_W     = $clog2(9 * 255 + 1);

    // Reciprocal constants for the divide by 6 and by 9
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_6     = (65536 + 5) / 6;
    localparam int RECIP_9     = (65536 + 8) / 9;
    localparam int DIV4_SHIFT  = 2;

    // Request codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // Divisor selection for the mean
    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } div_t;

    // Input request payload
    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_in;
    } bb3_in_t;

    // Result payload
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } bb3_out_t;

    // Which neighbours of the output pixel lie inside the frame
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } bb3_flags_t;

endpackage

[hdl/bb3_line_store.sv]
// Two line stores (rows above the input row) with read-modify-write and forwarding.
module bb3_line_store import bb3_pkg::*; (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_col,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_col,
    input  logic [PIX_W-1:0] wr_pix,
    output logic [PIX_W-1:0] top_o,
    output logic [PIX_W-1:0] mid_o
);

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic [PIX_W-1:0] upper_q_reg;
    logic [PIX_W-1:0] lower_q_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg;
    logic [PIX_W-1:0] fwd_mid_reg;

    // Column shifts up one row: middle row moves to upper, new pixel to lower
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_col] <= mid_o;
            lower_mem[wr_col] <= wr_pix;
        end
    end

    // Registered read; a write to the same column on the same edge is forwarded
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_q_reg <= upper_mem[rd_col];
            lower_q_reg <= lower_mem[rd_col];
            fwd_reg     <= wr_en && (wr_col == rd_col);
            fwd_top_reg <= mid_o;
            fwd_mid_reg <= wr_pix;
        end
    end

    assign top_o = fwd_reg ? fwd_top_reg : upper_q_reg;
    assign mid_o = fwd_reg ? fwd_mid_reg : lower_q_reg;

endmodule

[hdl/bb3_window.sv]
// 3x3 window registers and the masked neighbourhood sum.
module bb3_window import bb3_pkg::*; (
    input  logic             aclk,
    input  logic             shift_en,
    input  logic [PIX_W-1:0] top_i,
    input  logic [PIX_W-1:0] mid_i,
    input  logic [PIX_W-1:0] pix_i,
    input  logic             load_en,
    input  bb3_flags_t       flags_i,
    output logic [SUM_W-1:0] sum_o,
    output div_t             div_o
);

    logic [PIX_W-1:0] win_reg [3][3];
    logic [SUM_W-1:0] sum_reg;
    div_t             div_reg;
    logic [SUM_W-1:0] sum_next;
    div_t             div_next;

    // Window slides one column left; newest column enters on the right
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_i;
            win_reg[1][2] <= mid_i;
            win_reg[2][2] <= pix_i;
        end
    end

    // Sum of in-frame neighbours around the centre column
    always_comb begin
        sum_next = '0;
        for (int r = 0; r < 3; r++) begin
            if ((r == 1) || (r == 0 && flags_i.top_ok) || (r == 2 && flags_i.bot_ok)) begin
                sum_next = sum_next + SUM_W'(win_reg[r][1]);
                if (flags_i.left_ok) begin
                    sum_next = sum_next + SUM_W'(win_reg[r][0]);
                end
                if (flags_i.right_ok) begin
                    sum_next = sum_next + SUM_W'(win_reg[r][2]);
                end
            end
        end
    end

    // Interior: nine; edge: six; corner: four
    always_comb begin
        priority if ((flags_i.top_ok && flags_i.bot_ok) &&
                     (flags_i.left_ok && flags_i.right_ok)) begin
            div_next = DIV_9;
        end else if (!(flags_i.top_ok && flags_i.bot_ok) &&
                     !(flags_i.left_ok && flags_i.right_ok)) begin
            div_next = DIV_4;
        end else begin
            div_next = DIV_6;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            sum_reg <= sum_next;
            div_reg <= div_next;
        end
    end

    assign sum_o = sum_reg;
    assign div_o = div_reg;

endmodule

[hdl/bb3_divide.sv]
// Constant divide of the window sum and the result register.
module bb3_divide import bb3_pkg::*; (
    input  logic             aclk,
    input  logic             load_en,
    input  logic [SUM_W-1:0] sum_i,
    input  div_t             div_i,
    input  logic             last_i,
    output bb3_out_t         result_o
);

    logic [PROD_W-1:0] prod6;
    logic [PROD_W-1:0] prod9;
    logic [PIX_W-1:0]  quot;
    logic [PIX_W-1:0]  pixel_reg;
    logic              last_reg;

    // Multiply by rounded-up reciprocal; exact for sums this small
    always_comb begin
        prod6 = PROD_W'(sum_i) * PROD_W'(RECIP_6);
        prod9 = PROD_W'(sum_i) * PROD_W'(RECIP_9);
        unique case (div_i)
            DIV_4:   quot = PIX_W'(sum_i >> DIV4_SHIFT);
            DIV_6:   quot = prod6[RECIP_SHIFT +: PIX_W];
            DIV_9:   quot = prod9[RECIP_SHIFT +: PIX_W];
            default: quot = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            pixel_reg <= quot;
            last_reg  <= last_i;
        end
    end

    assign result_o.pixel_out  = pixel_reg;
    assign result_o.frame_last = last_reg;

endmodule

[hdl/box_blur_3x3_border_aware.sv]
// Top level: 3x3 border-aware box blur over a raster pixel stream.
//
// Requests enter on s_valid/s_ready with s_payload (operation, pixel_in);
// blurred pixels leave on m_valid/m_ready with m_payload (pixel_out,
// frame_last). A pixel request feeds the next source pixel; once all
// frame_width x frame_height pixels are in, frame_width + 1 drain requests
// flush the rest. Each result belongs to the source position frame_width + 1
// requests earlier, and the final one of a frame has frame_last set.
// Out-of-order requests (pixel after the frame is full, drain before it is)
// are accepted and dropped.
// Throughput: one request per cycle while the output is not stalled. The edge
// that accepts the request completing a result issues the line-store read;
// then window shift, sum and divide registers follow before m_valid rises.
// When m_ready is low the pipeline fills its bubbles first and then drops s_ready.
// Config writes (cfg_wr_en) clamp the size to 3..256 and restart the frame.
// Reset: size returns to 256 x 256, position to the frame start and the
// pipeline empties. The line stores are not cleared: rows above the frame
// never enter a mean, so no clearing pass is needed.
module box_blur_3x3_border_aware import bb3_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bb3_in_t              s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bb3_out_t             m_payload,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    // Geometry and position
    logic [W_W-1:0]   width_reg, width_next;
    logic [H_W-1:0]   height_reg, height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [W_W-1:0]   dim_clamped;

    // Pipeline
    logic             v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic [COL_W-1:0] p1_col_reg;
    logic [PIX_W-1:0] p1_pix_reg;
    logic             p1_emit_reg;
    bb3_flags_t       p1_flags_reg;
    bb3_flags_t       f2_reg;
    logic             last3_reg;

    logic out_free, free3, free2, adv1, adv2, adv3;
    logic accept, enter, is_drain, frame_done, end_mode, emit, wrap;
    logic [ROW_W-1:0] h_ext, h_plus1;
    logic [W_W-1:0]   col_inc;
    bb3_flags_t       flags_s0;

    logic [PIX_W-1:0] top_px, mid_px;
    logic [SUM_W-1:0] sum3;
    div_t             div3;

    // Stage handshakes: each stage moves when the next one is free
    assign out_free = !m_valid_reg || m_ready;
    assign adv3     = v3_reg && out_free;
    assign free3    = !v3_reg || out_free;
    assign adv2     = v2_reg && free3;
    assign free2    = !v2_reg || free3;
    assign adv1     = v1_reg && free2;
    assign s_ready  = !v1_reg || free2;
    assign accept   = s_valid && s_ready;

    // Request decode and the output position it completes
    always_comb begin
        h_ext      = ROW_W'(height_reg);
        h_plus1    = h_ext + 1'b1;
        is_drain   = (s_payload.operation == OP_DRAIN);
        frame_done = (row_reg >= h_ext);
        enter      = accept && (is_drain ? frame_done : !frame_done);
        end_mode   = (col_reg == '0);
        emit       = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && !end_mode);
        col_inc    = W_W'(col_reg) + 1'b1;
        wrap       = (col_inc == width_reg);

        // Start of a row completes the end of the row two above
        flags_s0.top_ok   = end_mode ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(2));
        flags_s0.bot_ok   = end_mode ? (row_reg <= h_ext) : (row_reg < h_ext);
        flags_s0.left_ok  = end_mode || (col_reg >= COL_W'(2));
        flags_s0.right_ok = !end_mode;
        flags_s0.last     = end_mode && (row_reg == h_plus1);
    end

    // Size clamp on write
    always_comb begin
        if (int'(cfg_wr_data) < DIM_MIN) begin
            dim_clamped = W_W'(DIM_MIN);
        end else if (int'(cfg_wr_data) > MAX_WIDTH) begin
            dim_clamped = W_W'(MAX_WIDTH);
        end else begin
            dim_clamped = W_W'(cfg_wr_data);
        end
    end

    // Geometry and position updates
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH: width_next = dim_clamped;
                CFG_FRAME_HEIGHT: begin
                    if (int'(cfg_wr_data) > HEIGHT_CAP) begin
                        height_next = H_W'(HEIGHT_CAP);
                    end else begin
                        height_next = H_W'(dim_clamped);
                    end
                end
                default: width_next = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end else if (enter) begin
            if (emit && flags_s0.last) begin
                col_next = '0;
                row_next = '0;
            end else if (wrap) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= W_W'(MAX_WIDTH);
            height_reg  <= H_W'(HEIGHT_CAP);
            col_reg     <= '0;
            row_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            if (s_ready) begin
                v1_reg <= enter;
            end
            if (free2) begin
                v2_reg <= v1_reg && p1_emit_reg;
            end
            if (free3) begin
                v3_reg <= v2_reg;
            end
            if (out_free) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (enter) begin
            p1_col_reg   <= col_reg;
            p1_pix_reg   <= is_drain ? '0 : s_payload.pixel_in;
            p1_emit_reg  <= emit;
            p1_flags_reg <= flags_s0;
        end
        if (adv1) begin
            f2_reg <= p1_flags_reg;
        end
        if (adv2) begin
            last3_reg <= f2_reg.last;
        end
    end

    bb3_line_store u_line_store (
        .aclk   (aclk),
        .rd_en  (enter),
        .rd_col (col_reg),
        .wr_en  (adv1),
        .wr_col (p1_col_reg),
        .wr_pix (p1_pix_reg),
        .top_o  (top_px),
        .mid_o  (mid_px)
    );

    bb3_window u_window (
        .aclk     (aclk),
        .shift_en (adv1),
        .top_i    (top_px),
        .mid_i    (mid_px),
        .pix_i    (p1_pix_reg),
        .load_en  (adv2),
        .flags_i  (f2_reg),
        .sum_o    (sum3),
        .div_o    (div3)
    );

    bb3_divide u_divide (
        .aclk     (aclk),
        .load_en  (adv3),
        .sum_i    (sum3),
        .div_i    (div3),
        .last_i   (last3_reg),
        .result_o (m_payload)
    );

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // Column position always lies inside the active row
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        W_W'(col_reg) < width_reg)
        else $error("column position beyond frame width");

    // Row position never passes the final drain row
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= h_plus1)
        else $error("row position beyond drain row");

    // The request completing the frame restarts the position
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (enter && emit && flags_s0.last && !cfg_wr_en) |=> (row_reg == '0 && col_reg == '0))
        else $error("position not cleared after last output");
`endif

endmodule
